@@ hw/rtl/bgre_pkg.sv @@
`timescale 1ns / 1ps

package bgre_pkg;

  localparam int CFG_W  = 6;
  localparam int IDX_W  = 1;
  localparam int POS_W  = 5;
  localparam int LEN_W  = 6;
  localparam int SLOT_W = 9;
  localparam int CNT_W  = 10;
  localparam int MAP_W  = 33;
  localparam int KIND_W = 2;

  localparam logic [IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [IDX_W-1:0] REG_COLS = 1'b1;

  localparam logic [CFG_W-1:0] SIZE_RESET = 6'd32;

  localparam logic [KIND_W-1:0] KIND_HORIZ   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VERT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

  typedef enum logic [1:0] {
    PART_HORIZ,
    PART_VERT,
    PART_SUMMARY
  } part_t;

  // Everything one cell produces: up to one horizontal run, one vertical run
  // and the grid summary.
  typedef struct packed {
    logic              h_emit;
    logic              v_emit;
    logic              sum_emit;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  h_first_col;
    logic [POS_W-1:0]  h_end_col;
    logic [LEN_W-1:0]  h_len;
    logic [SLOT_W-1:0] h_slot;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  v_first_row;
    logic [POS_W-1:0]  v_end_row;
    logic [LEN_W-1:0]  v_len;
    logic [SLOT_W-1:0] v_slot;
    logic [CNT_W-1:0]  h_total;
    logic [CNT_W-1:0]  v_total;
    logic [MAP_W-1:0]  lengths;
  } bundle_t;

endpackage

@@ hw/rtl/bgre_scan.sv @@
`timescale 1ns / 1ps

module bgre_scan #(
  parameter int MAX_DIM = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bgre_pkg::IDX_W-1:0]    cfg_index,
  input  logic [bgre_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          accept,
  input  logic                          is_black,
  output logic                          push,
  output bgre_pkg::bundle_t             bundle
);
  import bgre_pkg::*;

  localparam int PW = $clog2(MAX_DIM);
  localparam int LW = $clog2(MAX_DIM + 1);

  function automatic logic [PW-1:0] last_index(input logic [CFG_W-1:0] size);
    logic [PW-1:0] idx;
    if (size == '0) begin
      idx = '0;
    end else if (int'(size) > MAX_DIM) begin
      idx = PW'(MAX_DIM - 1);
    end else begin
      idx = PW'(size - CFG_W'(1));
    end
    return idx;
  endfunction

  function automatic logic [MAP_W-1:0] len_bit(input logic en, input logic [LW-1:0] len);
    logic [MAP_W-1:0] b;
    for (int i = 0; i < MAP_W; i++) begin
      b[i] = en && (int'(len) == i);
    end
    return b;
  endfunction

  logic [CFG_W-1:0]  grid_rows;
  logic [CFG_W-1:0]  grid_cols;
  logic [PW-1:0]     rows_last;
  logic [PW-1:0]     cols_last;

  logic [PW-1:0]     row_pos, row_pos_next;
  logic [PW-1:0]     col_pos, col_pos_next;
  logic [LW-1:0]     row_run_len, row_run_len_next;
  logic [PW-1:0]     row_run_start, row_run_start_next;
  logic [CNT_W-1:0]  row_run_count, row_run_count_next;
  logic [CNT_W-1:0]  col_run_count, col_run_count_next;
  logic [MAP_W-1:0]  length_bitmap, length_bitmap_next;
  logic [MAX_DIM-1:0] col_valid, col_valid_next;

  logic [PW+LW-1:0]  col_mem [MAX_DIM];
  logic [PW-1:0]     col_rd_start;
  logic [LW-1:0]     col_rd_len;
  logic [PW+LW-1:0]  col_wdata;

  logic              row_end, col_end, grid_end;
  logic              h_emit, v_emit;
  logic [LW-1:0]     h_len, v_len, col_len, col_len_next;
  logic [PW-1:0]     h_start, h_end;
  logic [PW-1:0]     v_start, v_end;
  logic [CNT_W-1:0]  h_count_upd, v_count_upd;
  logic [MAP_W-1:0]  bitmap_upd;

  assign rows_last = last_index(grid_rows);
  assign cols_last = last_index(grid_cols);
  assign row_end   = (col_pos == cols_last);
  assign col_end   = (row_pos == rows_last);
  assign grid_end  = row_end && col_end;
  assign col_len   = col_valid[col_pos] ? col_rd_len : '0;

  always_comb begin
    h_start          = (row_run_len == '0) ? col_pos : row_run_start;
    row_run_len_next = row_run_len;
    if (is_black) begin
      h_emit           = (row_run_len > LW'(1));
      h_len            = row_run_len;
      h_start          = row_run_start;
      h_end            = col_pos - PW'(1);
      row_run_len_next = '0;
    end else begin
      h_len = row_run_len + LW'(1);
      h_end = col_pos;
      if (row_end) begin
        h_emit           = (h_len > LW'(1));
        row_run_len_next = '0;
      end else begin
        h_emit           = 1'b0;
        row_run_len_next = h_len;
      end
    end

    v_start = (col_len == '0) ? row_pos : col_rd_start;
    if (is_black) begin
      v_emit       = (col_len > LW'(1));
      v_len        = col_len;
      v_start      = col_rd_start;
      v_end        = row_pos - PW'(1);
      col_len_next = '0;
    end else begin
      v_len = col_len + LW'(1);
      v_end = row_pos;
      if (col_end) begin
        v_emit       = (v_len > LW'(1));
        col_len_next = '0;
      end else begin
        v_emit       = 1'b0;
        col_len_next = v_len;
      end
    end

    h_count_upd = row_run_count + CNT_W'(h_emit);
    v_count_upd = col_run_count + CNT_W'(v_emit);
    bitmap_upd  = length_bitmap | len_bit(h_emit, h_len) | len_bit(v_emit, v_len);
    col_wdata   = {v_start, col_len_next};
  end

  always_comb begin
    row_pos_next       = row_pos;
    col_pos_next       = col_pos;
    row_run_start_next = row_run_start;
    row_run_count_next = row_run_count;
    col_run_count_next = col_run_count;
    length_bitmap_next = length_bitmap;
    col_valid_next     = col_valid;
    if (cfg_we) begin
      row_pos_next       = '0;
      col_pos_next       = '0;
      row_run_start_next = '0;
      row_run_count_next = '0;
      col_run_count_next = '0;
      length_bitmap_next = '0;
      col_valid_next     = '0;
    end else if (accept) begin
      row_run_start_next = h_start;
      if (grid_end) begin
        row_pos_next       = '0;
        col_pos_next       = '0;
        row_run_count_next = '0;
        col_run_count_next = '0;
        length_bitmap_next = '0;
        col_valid_next     = '0;
      end else begin
        row_run_count_next       = h_count_upd;
        col_run_count_next       = v_count_upd;
        length_bitmap_next       = bitmap_upd;
        col_valid_next[col_pos]  = 1'b1;
        if (row_end) begin
          col_pos_next = '0;
          row_pos_next = row_pos + PW'(1);
        end else begin
          col_pos_next = col_pos + PW'(1);
        end
      end
    end
  end

  assign push = accept && (h_emit || v_emit || grid_end);

  always_comb begin
    bundle             = '0;
    bundle.h_emit      = h_emit;
    bundle.v_emit      = v_emit;
    bundle.sum_emit    = grid_end;
    bundle.row         = POS_W'(row_pos);
    bundle.h_first_col = POS_W'(h_start);
    bundle.h_end_col   = POS_W'(h_end);
    bundle.h_len       = LEN_W'(h_len);
    bundle.h_slot      = SLOT_W'(row_run_count);
    bundle.col         = POS_W'(col_pos);
    bundle.v_first_row = POS_W'(v_start);
    bundle.v_end_row   = POS_W'(v_end);
    bundle.v_len       = LEN_W'(v_len);
    bundle.v_slot      = SLOT_W'(col_run_count);
    bundle.h_total     = h_count_upd;
    bundle.v_total     = v_count_upd;
    bundle.lengths     = bitmap_upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows     <= SIZE_RESET;
      grid_cols     <= SIZE_RESET;
      row_pos       <= '0;
      col_pos       <= '0;
      row_run_len   <= '0;
      row_run_start <= '0;
      row_run_count <= '0;
      col_run_count <= '0;
      length_bitmap <= '0;
      col_valid     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROWS: grid_rows <= cfg_data;
          REG_COLS: grid_cols <= cfg_data;
        endcase
        row_run_len <= '0;
      end else if (accept) begin
        row_run_len <= row_run_len_next;
      end
      row_pos       <= row_pos_next;
      col_pos       <= col_pos_next;
      row_run_start <= row_run_start_next;
      row_run_count <= row_run_count_next;
      col_run_count <= col_run_count_next;
      length_bitmap <= length_bitmap_next;
      col_valid     <= col_valid_next;
    end
  end

  // The column store is read one cell ahead; a write to the column about to
  // be read is forwarded.
  always_ff @(posedge clk) begin
    if (accept) begin
      col_mem[col_pos] <= col_wdata;
    end
    if (accept && (col_pos == col_pos_next)) begin
      {col_rd_start, col_rd_len} <= col_wdata;
    end else begin
      {col_rd_start, col_rd_len} <= col_mem[col_pos_next];
    end
  end

  a_pos_in_grid: assert property (@(posedge clk) disable iff (rst)
    (col_pos <= cols_last) && (row_pos <= rows_last))
    else $error("scan position outside the configured grid");

  a_row_run_bounded: assert property (@(posedge clk) disable iff (rst)
    int'(row_run_len) <= int'(col_pos))
    else $error("open row run longer than the cells scanned in this row");

  a_grid_clears: assert property (@(posedge clk) disable iff (rst)
    accept && grid_end |=> (row_run_count == '0) && (col_run_count == '0) &&
                           (length_bitmap == '0) && (col_valid == '0))
    else $error("scan state not cleared after the final cell");

endmodule

@@ hw/rtl/bgre_out.sv @@
`timescale 1ns / 1ps

module bgre_out (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  bgre_pkg::bundle_t             bundle,
  output logic                          space,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bgre_pkg::KIND_W-1:0]   kind,
  output logic [bgre_pkg::POS_W-1:0]    first_row,
  output logic [bgre_pkg::POS_W-1:0]    first_col,
  output logic [bgre_pkg::POS_W-1:0]    end_row,
  output logic [bgre_pkg::POS_W-1:0]    end_col,
  output logic [bgre_pkg::LEN_W-1:0]    run_length,
  output logic [bgre_pkg::SLOT_W-1:0]   slot_index,
  output logic [bgre_pkg::CNT_W-1:0]    horizontal_total,
  output logic [bgre_pkg::CNT_W-1:0]    vertical_total,
  output logic [bgre_pkg::MAP_W-1:0]    lengths_seen,
  output logic                          last
);
  import bgre_pkg::*;

  bundle_t     fifo [2];
  logic        wptr, rptr;
  logic [1:0]  count, count_next;
  logic        h_done, v_done;
  bundle_t     head;
  part_t       sel;
  logic        xfer, pop;

  assign head      = fifo[rptr];
  assign out_valid = (count != 2'd0);
  assign space     = (count != 2'd2);
  assign xfer      = out_valid && out_ready;
  assign pop       = xfer && last;

  always_comb begin
    priority if (head.h_emit && !h_done) begin
      sel = PART_HORIZ;
    end else if (head.v_emit && !v_done) begin
      sel = PART_VERT;
    end else begin
      sel = PART_SUMMARY;
    end
  end

  always_comb begin
    kind             = KIND_SUMMARY;
    first_row        = '0;
    first_col        = '0;
    end_row          = '0;
    end_col          = '0;
    run_length       = '0;
    slot_index       = '0;
    horizontal_total = '0;
    vertical_total   = '0;
    lengths_seen     = '0;
    last             = 1'b1;
    unique case (sel)
      PART_HORIZ: begin
        kind       = KIND_HORIZ;
        first_row  = head.row;
        first_col  = head.h_first_col;
        end_row    = head.row;
        end_col    = head.h_end_col;
        run_length = head.h_len;
        slot_index = head.h_slot;
        last       = !(head.v_emit || head.sum_emit);
      end
      PART_VERT: begin
        kind       = KIND_VERT;
        first_row  = head.v_first_row;
        first_col  = head.col;
        end_row    = head.v_end_row;
        end_col    = head.col;
        run_length = head.v_len;
        slot_index = head.v_slot;
        last       = !head.sum_emit;
      end
      PART_SUMMARY: begin
        horizontal_total = head.h_total;
        vertical_total   = head.v_total;
        lengths_seen     = head.lengths;
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  assign count_next = count + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr   <= 1'b0;
      rptr   <= 1'b0;
      count  <= '0;
      h_done <= 1'b0;
      v_done <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr   <= !rptr;
        h_done <= 1'b0;
        v_done <= 1'b0;
      end else if (xfer) begin
        if (sel == PART_HORIZ) begin
          h_done <= 1'b1;
        end
        if (sel == PART_VERT) begin
          v_done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= bundle;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> count != 2'd2)
    else $error("cell pushed into a full result queue");

  a_part_order: assert property (@(posedge clk) disable iff (rst)
    v_done |-> (h_done || !head.h_emit))
    else $error("vertical run sent before the horizontal run of the same cell");

endmodule

@@ hw/rtl/binary_grid_run_extractor.sv @@
`timescale 1ns / 1ps

// Cells of a binary grid arrive on the input channel in raster order, one
// per transfer, with is_black set for a blocked cell. Every horizontal and
// vertical run of two or more open cells is reported on the output channel
// in the cycle order in which it completes, followed after the final cell
// of the grid by a summary transfer with the run totals and the bitmap of
// run lengths. The last flag marks the final result caused by a cell.
// Grid size is set through the write port (index 0 rows, index 1 columns);
// any write restarts the grid.
// A taken cell's results are registered in a two-entry result queue. One
// cell per cycle is sustained while each cell yields at most one result
// and the receiver does not stall; a cell with two or three results holds
// the output for one transfer per result. The queue lets input continue
// while the receiver stalls, and in_ready falls only when it is full.
// Reset selects a 32 by 32 grid and clears the scan; there is no clearing
// pass, so the block takes cells from the first cycle after reset.
module binary_grid_run_extractor #(
  parameter int MAX_DIM = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bgre_pkg::IDX_W-1:0]    cfg_index,
  input  logic [bgre_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          is_black,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bgre_pkg::KIND_W-1:0]   kind,
  output logic [bgre_pkg::POS_W-1:0]    first_row,
  output logic [bgre_pkg::POS_W-1:0]    first_col,
  output logic [bgre_pkg::POS_W-1:0]    end_row,
  output logic [bgre_pkg::POS_W-1:0]    end_col,
  output logic [bgre_pkg::LEN_W-1:0]    run_length,
  output logic [bgre_pkg::SLOT_W-1:0]   slot_index,
  output logic [bgre_pkg::CNT_W-1:0]    horizontal_total,
  output logic [bgre_pkg::CNT_W-1:0]    vertical_total,
  output logic [bgre_pkg::MAP_W-1:0]    lengths_seen,
  output logic                          last
);
  import bgre_pkg::*;

  logic    accept;
  logic    push;
  logic    space;
  bundle_t bundle;

  assign in_ready = space;
  assign accept   = in_valid && space;

  bgre_scan #(
    .MAX_DIM (MAX_DIM)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .is_black  (is_black),
    .push      (push),
    .bundle    (bundle)
  );

  bgre_out u_out (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .bundle           (bundle),
    .space            (space),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .kind             (kind),
    .first_row        (first_row),
    .first_col        (first_col),
    .end_row          (end_row),
    .end_col          (end_col),
    .run_length       (run_length),
    .slot_index       (slot_index),
    .horizontal_total (horizontal_total),
    .vertical_total   (vertical_total),
    .lengths_seen     (lengths_seen),
    .last             (last)
  );

endmodule

@@ dv/binary_grid_run_extractor_tb.sv @@
`timescale 1ns / 1ps

module binary_grid_run_extractor_tb;
  import bgre_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  first_row;
    logic [POS_W-1:0]  first_col;
    logic [POS_W-1:0]  end_row;
    logic [POS_W-1:0]  end_col;
    logic [LEN_W-1:0]  run_length;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  h_total;
    logic [CNT_W-1:0]  v_total;
    logic [MAP_W-1:0]  lengths;
    logic              last;
  } run_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic is_black = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KIND_W-1:0] kind;
  logic [POS_W-1:0] first_row;
  logic [POS_W-1:0] first_col;
  logic [POS_W-1:0] end_row;
  logic [POS_W-1:0] end_col;
  logic [LEN_W-1:0] run_length;
  logic [SLOT_W-1:0] slot_index;
  logic [CNT_W-1:0] horizontal_total;
  logic [CNT_W-1:0] vertical_total;
  logic [MAP_W-1:0] lengths_seen;
  logic last;

  int idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  run_result_t expected_runs [$];

  logic [CFG_W-1:0]  rows_sz = SIZE_RESET;
  logic [CFG_W-1:0]  cols_sz = SIZE_RESET;
  logic [POS_W-1:0]  cur_row;
  logic [POS_W-1:0]  cur_col;
  logic [LEN_W-1:0]  hrun_len;
  logic [POS_W-1:0]  hrun_start;
  logic [LEN_W-1:0]  vrun_len [32];
  logic [POS_W-1:0]  vrun_start [32];
  logic [CNT_W-1:0]  hrun_count;
  logic [CNT_W-1:0]  vrun_count;
  logic [MAP_W-1:0]  len_map;

  binary_grid_run_extractor dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .is_black(is_black),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .first_row(first_row),
    .first_col(first_col),
    .end_row(end_row),
    .end_col(end_col),
    .run_length(run_length),
    .slot_index(slot_index),
    .horizontal_total(horizontal_total),
    .vertical_total(vertical_total),
    .lengths_seen(lengths_seen),
    .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("binary_grid_run_extractor_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result();
  end

  function automatic int eff_size(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > 32) return 32;
    return int'(v);
  endfunction

  function automatic void clear_scan();
    cur_row = '0;
    cur_col = '0;
    hrun_len = '0;
    hrun_start = '0;
    for (int i = 0; i < 32; i++) begin
      vrun_len[i] = '0;
      vrun_start[i] = '0;
    end
    hrun_count = '0;
    vrun_count = '0;
    len_map = '0;
  endfunction

  function automatic run_result_t make_run(input logic [KIND_W-1:0] k, input int sr,
                                           input int sc, input int er, input int ec,
                                           input int len, input int slot);
    run_result_t rec;
    rec.kind = k;
    rec.first_row = POS_W'(sr);
    rec.first_col = POS_W'(sc);
    rec.end_row = POS_W'(er);
    rec.end_col = POS_W'(ec);
    rec.run_length = LEN_W'(len);
    rec.slot = SLOT_W'(slot);
    rec.h_total = '0;
    rec.v_total = '0;
    rec.lengths = '0;
    rec.last = 1'b0;
    if (k != KIND_SUMMARY && len < MAP_W) len_map[len] = 1'b1;
    return rec;
  endfunction

  task automatic predict_cell(input logic black);
    int rows;
    int cols;
    int r;
    int c;
    int vlen;
    int n;
    bit row_end;
    bit grid_end;
    run_result_t found [3];
    rows = eff_size(rows_sz);
    cols = eff_size(cols_sz);
    r = int'(cur_row);
    c = int'(cur_col);
    n = 0;
    row_end = (c + 1 >= cols);
    grid_end = row_end && (r + 1 >= rows);

    if (black) begin
      if (hrun_len > 1) begin
        found[n] = make_run(KIND_HORIZ, r, int'(hrun_start), r, c - 1, int'(hrun_len),
                            int'(hrun_count));
        n++;
        hrun_count++;
      end
      hrun_len = '0;
    end else begin
      if (hrun_len == 0) hrun_start = POS_W'(c);
      hrun_len++;
    end
    if (row_end) begin
      if (hrun_len > 1) begin
        found[n] = make_run(KIND_HORIZ, r, int'(hrun_start), r, c, int'(hrun_len),
                            int'(hrun_count));
        n++;
        hrun_count++;
      end
      hrun_len = '0;
    end

    vlen = int'(vrun_len[c]);
    if (black) begin
      if (vlen > 1) begin
        found[n] = make_run(KIND_VERT, int'(vrun_start[c]), c, r - 1, c, vlen,
                            int'(vrun_count));
        n++;
        vrun_count++;
      end
      vlen = 0;
    end else begin
      if (vlen == 0) vrun_start[c] = POS_W'(r);
      vlen++;
    end
    if (r + 1 >= rows) begin
      if (vlen > 1) begin
        found[n] = make_run(KIND_VERT, int'(vrun_start[c]), c, r, c, vlen,
                            int'(vrun_count));
        n++;
        vrun_count++;
      end
      vlen = 0;
    end
    vrun_len[c] = LEN_W'(vlen);

    if (grid_end) begin
      found[n] = make_run(KIND_SUMMARY, 0, 0, 0, 0, 0, 0);
      found[n].h_total = hrun_count;
      found[n].v_total = vrun_count;
      found[n].lengths = len_map;
      n++;
    end
    if (n > 0) found[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) begin
      expected_runs.push_back(found[i]);
    end

    if (grid_end) begin
      clear_scan();
    end else if (row_end) begin
      cur_col = '0;
      cur_row = POS_W'(r + 1);
    end else begin
      cur_col = POS_W'(c + 1);
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (error_count < 100) $display("mismatch: %s", msg);
    error_count++;
  endtask

  task automatic check_field(input string field, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, expected %0h", field, got, want));
  endtask

  task automatic check_result();
    run_result_t want;
    if (expected_runs.size() == 0) begin
      report_mismatch($sformatf("transfer of kind %0d with no result expected", kind));
    end else begin
      want = expected_runs.pop_front();
      check_field("kind", 64'(kind), 64'(want.kind));
      check_field("first_row", 64'(first_row), 64'(want.first_row));
      check_field("first_col", 64'(first_col), 64'(want.first_col));
      check_field("end_row", 64'(end_row), 64'(want.end_row));
      check_field("end_col", 64'(end_col), 64'(want.end_col));
      check_field("run_length", 64'(run_length), 64'(want.run_length));
      check_field("slot_index", 64'(slot_index), 64'(want.slot));
      check_field("horizontal_total", 64'(horizontal_total), 64'(want.h_total));
      check_field("vertical_total", 64'(vertical_total), 64'(want.v_total));
      check_field("lengths_seen", 64'(lengths_seen), 64'(want.lengths));
      check_field("last", 64'(last), 64'(want.last));
    end
  endtask

  task automatic send_cell(input logic black);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    is_black <= black;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_cell(black);
  endtask

  // Waits until every expected result has been taken and the last cell has
  // had time to leave the pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ROWS) begin
      rows_sz = value;
    end else begin
      cols_sz = value;
    end
    clear_scan();
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 75) return CFG_W'($urandom_range(6, 1));
    if (roll < 85) return CFG_W'($urandom_range(31, 7));
    case ($urandom_range(3))
      0: return '0;
      1: return CFG_W'(32);
      2: return CFG_W'(33);
      default: return '1;
    endcase
  endfunction

  // Three rows of the reset grid; the third row is black apart from column 7
  // and closes the vertical runs of the first two rows in every other column.
  task automatic test_reset_size();
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 32; c++) begin
        send_cell(c != 7 && (r == 2 || $urandom_range(3) == 0));
      end
    end
  endtask

  task automatic test_directed();
    logic [11:0] pattern;
    write_size(REG_ROWS, '0);
    write_size(REG_COLS, '0);
    send_cell(1'b0);
    send_cell(1'b1);
    write_size(REG_ROWS, CFG_W'(2));
    write_size(REG_COLS, CFG_W'(2));
    repeat (4) send_cell(1'b0);
    write_size(REG_ROWS, CFG_W'(3));
    write_size(REG_COLS, CFG_W'(4));
    pattern = 12'b0010_0001_1000;
    for (int i = 11; i >= 0; i--) begin
      send_cell(pattern[i]);
    end
    for (int i = 0; i < 5; i++) begin
      send_cell(1'($urandom_range(1)));
    end
    write_size(REG_COLS, CFG_W'(4));
  endtask

  task automatic test_random();
    int items;
    int cells;
    int density;
    logic [CFG_W-1:0] rows_val;
    logic [CFG_W-1:0] cols_val;
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1) ? 84 : (phase == 3) ? 37 : 0;
      stall_pct = (phase == 2) ? 84 : (phase == 3) ? 37 : 0;
      items = 0;
      while (items < 24) begin
        rows_val = pick_size();
        cols_val = pick_size();
        if (items == 0 && phase == 0) begin
          rows_val = '1;
          cols_val = CFG_W'(1);
        end
        if (items == 0 && phase == 1) begin
          rows_val = CFG_W'(1);
          cols_val = CFG_W'(33);
        end
        if (eff_size(rows_val) * eff_size(cols_val) > 64) begin
          if ($urandom_range(1)) begin
            rows_val = CFG_W'($urandom_range(3, 1));
          end else begin
            cols_val = CFG_W'($urandom_range(3, 1));
          end
        end
        write_size(REG_ROWS, rows_val);
        write_size(REG_COLS, cols_val);
        cells = eff_size(rows_val) * eff_size(cols_val);
        if (cells > 1 && $urandom_range(9) == 0) cells = int'($urandom_range(cells - 1, 1));
        case ($urandom_range(3))
          0: density = 5;
          1: density = 25;
          2: density = 50;
          default: density = 85;
        endcase
        repeat (cells) send_cell($urandom_range(99) < density);
        items += cells;
      end
    end
  endtask

  initial begin
    clear_scan();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_size();
    test_directed();
    test_random();
    settle();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("binary_grid_run_extractor_tb: clean");
    end else begin
      $display("binary_grid_run_extractor_tb: errors");
    end
    $finish;
  end

endmodule
